// ----- hw/rtl/rtbg_pkg.sv -----
// rtbg_pkg: shared types and codes for the rotary turn and button gesture detector
// no dependencies; imported by the input stage, the core and the top level

package rtbg_pkg;

  // gesture codes on the result
  localparam logic [1:0] GEST_NONE   = 2'd0;
  localparam logic [1:0] GEST_SINGLE = 2'd1;
  localparam logic [1:0] GEST_DOUBLE = 2'd2;
  localparam logic [1:0] GEST_LONG   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LONG_PRESS_TIME     = 2'd0;
  localparam logic [1:0] REG_DOUBLE_PRESS_WINDOW = 2'd1;
  localparam logic [1:0] REG_INITIAL_POSITION    = 2'd2;

  // one poll as accepted from the input channel
  typedef struct packed {
    logic [31:0]        time_now;
    logic               button_down;
    logic signed [15:0] position;
  } poll_t;

  // one result item
  typedef struct packed {
    logic       turned_right;
    logic       turned_left;
    logic [1:0] gesture;
  } result_t;

  // configuration seen by the core
  typedef struct packed {
    logic [15:0]        long_press_time;
    logic [15:0]        double_press_window;
    logic               load_position;
    logic signed [15:0] load_value;
  } cfg_t;

endpackage

// ----- hw/rtl/rtbg_in_stage.sv -----
// rtbg_in_stage: input register that holds one accepted poll
// depends on rtbg_pkg for the poll type

module rtbg_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtbg_pkg::poll_t in_poll,
  input  logic           advance,
  output logic           held_valid,
  output rtbg_pkg::poll_t held_poll
);
  import rtbg_pkg::*;

  // take a new poll when empty or when the held one moves on this cycle
  assign in_ready = !held_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_poll <= in_poll;
    end
  end

endmodule

// ----- hw/rtl/rtbg_core.sv -----
// rtbg_core: turn detection, button phase machine and the result register
// depends on rtbg_pkg for poll, result and config types and gesture codes

module rtbg_core (
  input  logic             clk,
  input  logic             rst,
  input  rtbg_pkg::cfg_t   cfg,
  input  logic             held_valid,
  input  rtbg_pkg::poll_t  held_poll,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output rtbg_pkg::result_t result
);
  import rtbg_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_WAIT    = 2'd2
  } phase_t;

  phase_t             phase, phase_next;
  logic [31:0]        press_start_time, press_start_time_next;
  logic [31:0]        release_time, release_time_next;
  logic signed [15:0] last_position;
  logic [31:0]        held_ms;
  logic [31:0]        since_release;
  logic               long_hit;
  logic               window_hit;
  result_t            result_next;

  // move the held poll into the result register when it is free
  assign advance = held_valid && (!out_valid || out_ready);

  // elapsed times modulo 2^32
  assign held_ms       = held_poll.time_now - press_start_time;
  assign since_release = held_poll.time_now - release_time;
  assign long_hit      = held_ms >= {16'd0, cfg.long_press_time};
  assign window_hit    = since_release >= {16'd0, cfg.double_press_window};

  // classify the poll
  always_comb begin
    phase_next            = phase;
    press_start_time_next = press_start_time;
    release_time_next     = release_time;
    result_next.turned_right = held_poll.position > last_position;
    result_next.turned_left  = held_poll.position < last_position;
    result_next.gesture      = GEST_NONE;
    case (phase)
      PH_PRESSED: begin
        if (!held_poll.button_down) begin
          release_time_next = held_poll.time_now;
          if (long_hit) begin
            result_next.gesture = GEST_LONG;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_WAIT;
          end
        end else if (long_hit) begin
          result_next.gesture = GEST_LONG;
          phase_next = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (held_poll.button_down) begin
          result_next.gesture = GEST_DOUBLE;
          phase_next = PH_IDLE;
        end else if (window_hit) begin
          result_next.gesture = GEST_SINGLE;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        if (held_poll.button_down) begin
          press_start_time_next = held_poll.time_now;
          phase_next = PH_PRESSED;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      press_start_time <= 32'd0;
      release_time     <= 32'd0;
      last_position    <= 16'sd0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.load_position) begin
        last_position <= cfg.load_value;
      end else if (advance) begin
        last_position <= held_poll.position;
      end
      if (advance) begin
        phase            <= phase_next;
        press_start_time <= press_start_time_next;
        release_time     <= release_time_next;
        result           <= result_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/rotary_turn_and_button_gesture_detector.sv -----
// rotary_turn_and_button_gesture_detector: top level, config registers and assertions
// depends on rtbg_pkg, rtbg_in_stage and rtbg_core

// Each poll (timestamp in ms, button level, encoder position) yields one result: a right or
// left turn flag against the previous position and a button gesture (none, single, double,
// long). A poll passes an input register and then the compare and phase logic into the result
// register, so one poll is taken every clock while the result register is not blocked, and its
// result is presented from the result register, which lets the next poll be taken while a result
// waits. Long presses repeat every long_press_time while held. Writing initial_position also
// sets the position the next poll is compared against. Write configuration only while idle.

module rotary_turn_and_button_gesture_detector (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        time_now,
  input  logic               button_down,
  input  logic signed [15:0] position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               turned_right,
  output logic               turned_left,
  output logic [1:0]         gesture,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import rtbg_pkg::*;

  logic [15:0] long_press_time;
  logic [15:0] double_press_window;
  cfg_t        cfg;
  poll_t       in_poll;
  poll_t       held_poll;
  logic        held_valid;
  logic        advance;
  result_t     result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_time     <= 16'd800;
      double_press_window <= 16'd300;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS_TIME:     long_press_time     <= cfg_data;
        REG_DOUBLE_PRESS_WINDOW: double_press_window <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.long_press_time     = long_press_time;
  assign cfg.double_press_window = double_press_window;
  assign cfg.load_position       = cfg_we && (cfg_index == REG_INITIAL_POSITION);
  assign cfg.load_value          = cfg_data;

  assign in_poll.time_now    = time_now;
  assign in_poll.button_down = button_down;
  assign in_poll.position    = position;

  rtbg_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_poll    (in_poll),
    .advance    (advance),
    .held_valid (held_valid),
    .held_poll  (held_poll)
  );

  rtbg_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_poll  (held_poll),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign turned_right = result.turned_right;
  assign turned_left  = result.turned_left;
  assign gesture      = result.gesture;

  // the input side stalls only behind a blocked full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (held_valid && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // a turn is never both ways
  a_turn_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(turned_right && turned_left))
    else $error("turn flagged both ways");

  // nothing is shown in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (!out_valid && !held_valid))
    else $error("pipeline not empty after reset");

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for rotary_turn_and_button_gesture_detector
// depends on rtbg_pkg and the rtl top level; a queue-fed driver, a predictor and a checking monitor

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtbg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 200;

  // button machine phases as seen by the predictor
  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_PRESSED     = 2'd1,
    PH_WAIT_SECOND = 2'd2
  } button_phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        time_now = '0;
  logic               button_down = 1'b0;
  logic signed [15:0] position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               turned_right;
  logic               turned_left;
  logic [1:0]         gesture;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // predictor copy of configuration and state
  logic [15:0]        hold_limit_ms;
  logic [15:0]        double_window_ms;
  logic signed [15:0] last_pos;
  button_phase_t      btn_phase;
  logic [31:0]        press_ms;
  logic [31:0]        release_ms;

  // polls waiting to be sent and results waiting to arrive
  poll_t              poll_backlog[$];
  result_t            turn_gesture_due[$];
  result_t            due_result;

  // stimulus generator state
  logic [31:0]        ms_clock;
  logic               btn_level;
  logic signed [15:0] enc_pos;

  int                 send_idle_pct = 30;
  int                 recv_stall_pct = 30;
  int                 send_gap = 0;
  int                 recv_stall = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;

  rotary_turn_and_button_gesture_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .time_now     (time_now),
    .button_down  (button_down),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .turned_right (turned_right),
    .turned_left  (turned_left),
    .gesture      (gesture),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // wait in cycles before the next transaction on one side
  function automatic int draw_wait(int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(0, 19);
    return 0;
  endfunction

  // turn flags and button gesture for one poll, advancing the predicted state
  function automatic result_t classify_poll(poll_t p);
    result_t     r;
    logic [31:0] held_for;
    logic [31:0] since_release;
    r = '0;
    held_for = p.time_now - press_ms;
    since_release = p.time_now - release_ms;
    if ($signed(p.position) > $signed(last_pos)) begin
      r.turned_right = 1'b1;
    end else if ($signed(p.position) < $signed(last_pos)) begin
      r.turned_left = 1'b1;
    end
    last_pos = p.position;
    r.gesture = GEST_NONE;
    case (btn_phase)
      PH_PRESSED: begin
        if (!p.button_down) begin
          release_ms = p.time_now;
          if (held_for >= {16'd0, hold_limit_ms}) begin
            r.gesture = GEST_LONG;
            btn_phase = PH_IDLE;
          end else begin
            btn_phase = PH_WAIT_SECOND;
          end
        end else if (held_for >= {16'd0, hold_limit_ms}) begin
          r.gesture = GEST_LONG;
          btn_phase = PH_IDLE;
        end
      end
      PH_WAIT_SECOND: begin
        if (p.button_down) begin
          r.gesture = GEST_DOUBLE;
          btn_phase = PH_IDLE;
        end else if (since_release >= {16'd0, double_window_ms}) begin
          r.gesture = GEST_SINGLE;
          btn_phase = PH_IDLE;
        end
      end
      default: begin
        if (p.button_down) begin
          press_ms = p.time_now;
          btn_phase = PH_PRESSED;
        end else begin
          btn_phase = PH_IDLE;
        end
      end
    endcase
    return r;
  endfunction

  // input side: send queued polls, predict on every accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        turn_gesture_due.push_back(classify_poll({time_now, button_down, position}));
      end
      if (in_valid && !in_ready) begin
        // hold the payload until taken
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (poll_backlog.size() != 0) begin
        poll_t nxt;
        nxt = poll_backlog.pop_front();
        time_now <= nxt.time_now;
        button_down <= nxt.button_down;
        position <= nxt.position;
        in_valid <= 1'b1;
        send_gap = draw_wait(send_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random stalls, compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (turn_gesture_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result right=%0b left=%0b gesture=%0d",
                     $time, turned_right, turned_left, gesture);
        end else begin
          due_result = turn_gesture_due.pop_front();
          if (turned_right !== due_result.turned_right ||
              turned_left !== due_result.turned_left ||
              gesture !== due_result.gesture) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: mismatch expected right=%0b left=%0b gesture=%0d, %s%0b %s%0b %s%0d",
                       $time, due_result.turned_right, due_result.turned_left,
                       due_result.gesture, "actual right=", turned_right, "left=",
                       turned_left, "gesture=", gesture);
          end
        end
        recv_stall = draw_wait(recv_stall_pct);
      end
      if (recv_stall > 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one register write, mirrored into the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LONG_PRESS_TIME:     hold_limit_ms = val;
      REG_DOUBLE_PRESS_WINDOW: double_window_ms = val;
      REG_INITIAL_POSITION:    last_pos = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] hold, input logic [15:0] window,
                                input logic [15:0] start_pos);
    write_reg(REG_LONG_PRESS_TIME, hold);
    write_reg(REG_DOUBLE_PRESS_WINDOW, window);
    write_reg(REG_INITIAL_POSITION, start_pos);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_poll(input logic [31:0] t, input logic down, input logic [15:0] pos);
    poll_backlog.push_back({t, down, pos});
  endtask

  // press and release sequences with timing scaled to the thresholds, plus some noise
  task automatic queue_gesture_polls(input int count, input int step_max);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) ms_clock = $urandom;
      else ms_clock = ms_clock + $urandom_range(0, step_max);
      roll = $urandom_range(0, 99);
      if (roll < 5) btn_level = 1'($urandom_range(0, 1));
      else if (roll < 40) btn_level = ~btn_level;
      roll = $urandom_range(0, 99);
      if (roll < 40) enc_pos = enc_pos;
      else if (roll < 80) enc_pos = 16'(enc_pos + $urandom_range(0, 6) - 3);
      else if (roll < 90) enc_pos = 16'($urandom);
      else enc_pos = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      add_poll(ms_clock, btn_level, enc_pos);
    end
  endtask

  // block until every poll is sent and every result has arrived
  task automatic wait_drained();
    do @(posedge clk);
    while (poll_backlog.size() != 0 || in_valid || turn_gesture_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int hold, input int window, input int start_pos,
                           input int count, input int in_pct, input int out_pct);
    int step_max;
    apply_settings(16'(hold), 16'(window), 16'(start_pos));
    step_max = ((hold > window) ? hold : window) / 2 + 2;
    @(negedge clk);
    send_idle_pct = in_pct;
    recv_stall_pct = out_pct;
    queue_gesture_polls(count, step_max);
    wait_drained();
  endtask

  // run length guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // sequence of phases
  initial begin
    hold_limit_ms = 16'd800;
    double_window_ms = 16'd300;
    last_pos = '0;
    btn_phase = PH_IDLE;
    press_ms = '0;
    release_ms = '0;
    ms_clock = '0;
    btn_level = 1'b0;
    enc_pos = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed polls at reset settings: turns at the extremes, every gesture,
    // exact thresholds, repeating long press, timestamp wrap and backward jump
    add_poll(32'd0,    1'b0, 16'h0000);
    add_poll(32'd10,   1'b0, 16'h7FFF);
    add_poll(32'd20,   1'b0, 16'h8000);
    add_poll(32'd30,   1'b1, 16'h8000);
    add_poll(32'd100,  1'b0, 16'h8000);
    add_poll(32'd200,  1'b1, 16'h8001);
    add_poll(32'd250,  1'b1, 16'h8000);
    add_poll(32'd300,  1'b0, 16'h8000);
    add_poll(32'd600,  1'b0, 16'h0000);
    add_poll(32'd700,  1'b1, 16'h0000);
    add_poll(32'd1499, 1'b1, 16'hFFFF);
    add_poll(32'd1500, 1'b1, 16'h0000);
    add_poll(32'd1501, 1'b1, 16'h0000);
    add_poll(32'd2301, 1'b0, 16'h0000);
    add_poll(32'd2302, 1'b1, 16'h0001);
    add_poll(32'd2303, 1'b0, 16'h0001);
    add_poll(32'd2602, 1'b0, 16'h0001);
    add_poll(32'd2603, 1'b0, 16'h0001);
    add_poll(32'hFFFF_FFFF, 1'b1, 16'h7FFF);
    add_poll(32'h0000_0100, 1'b1, 16'h8000);
    add_poll(32'h0000_031F, 1'b1, 16'h8000);
    add_poll(32'h0000_0300, 1'b1, 16'h0000);
    add_poll(32'h0000_0100, 1'b0, 16'h0000);
    add_poll(32'h0000_0050, 1'b0, 16'h7FFF);
    add_poll(32'h0000_0051, 1'b0, 16'h7FFF);
    wait_drained();

    // extremes of every register, zero thresholds, then random settings
    run_phase(1, 1, -32768, 200, 0, 0);
    run_phase(65535, 65535, 32767, 150, 40, 40);
    run_phase(0, 0, 0, 50, 20, 60);
    for (int ph = 0; ph < 6; ph++) begin
      run_phase($urandom_range(2, 400), $urandom_range(1, 300), $urandom_range(0, 65535),
                240, (ph == 2) ? 0 : $urandom_range(5, 80),
                (ph == 2) ? 0 : $urandom_range(5, 80));
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && turn_gesture_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
